>>> src/pfla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfla_pkg;

    localparam int ALIGN_W  = 13;
    localparam int FSIZE_W  = 29;
    localparam int FCOUNT_W = 5;
    localparam int OPCODE_W = 2;
    localparam int BC_W     = 32;
    localparam int OFFSET_W = 32;
    localparam int FILL_W   = 32;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    localparam int MAX_FRAMES_DEF = 16;

    localparam logic [ALIGN_W-1:0]  ALIGN_RST  = ALIGN_W'(256);
    localparam logic [FSIZE_W-1:0]  FSIZE_RST  = FSIZE_W'(65536);
    localparam logic [FCOUNT_W-1:0] FCOUNT_RST = FCOUNT_W'(1);

    localparam logic [1:0] REG_ALIGNMENT   = 2'd0;
    localparam logic [1:0] REG_FRAME_SIZE  = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd2;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SWAP  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BC_W-1:0]     byte_count;
    } req_word_t;

    typedef struct packed {
        logic                granted;
        logic [OFFSET_W-1:0] buffer_offset;
    } rsp_word_t;

    typedef struct packed {
        logic [ALIGN_W-1:0]  alignment;
        logic [FSIZE_W-1:0]  frame_size;
        logic [FCOUNT_W-1:0] frame_count;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic round_en;
        logic commit_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic                req_div;
        logic [OPCODE_W-1:0] opcode;
        logic                div_last;
        logic                out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> src/pfla_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pfla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/pfla_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pfla_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pfla_pkg::APB_AW-1:0] paddr,
    input  wire logic [pfla_pkg::APB_DW-1:0] pwdata,
    output logic      [pfla_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output pfla_pkg::cfg_t                  cfg
);

    pfla_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alignment   <= pfla_pkg::ALIGN_RST;
            cfg_reg.frame_size  <= pfla_pkg::FSIZE_RST;
            cfg_reg.frame_count <= pfla_pkg::FCOUNT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                pfla_pkg::REG_ALIGNMENT:
                    cfg_reg.alignment <= pwdata[pfla_pkg::ALIGN_W-1:0];
                pfla_pkg::REG_FRAME_SIZE:
                    cfg_reg.frame_size <= pwdata[pfla_pkg::FSIZE_W-1:0];
                pfla_pkg::REG_FRAME_COUNT:
                    cfg_reg.frame_count <= pwdata[pfla_pkg::FCOUNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pfla_pkg::REG_ALIGNMENT:
                prdata = pfla_pkg::APB_DW'(cfg_reg.alignment);
            pfla_pkg::REG_FRAME_SIZE:
                prdata = pfla_pkg::APB_DW'(cfg_reg.frame_size);
            pfla_pkg::REG_FRAME_COUNT:
                prdata = pfla_pkg::APB_DW'(cfg_reg.frame_count);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/pfla_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pfla_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire pfla_pkg::sts_t sts,
    output pfla_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIVIDE = 5'b00010,
        S_ROUND  = 5'b00100,
        S_COMMIT = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.req_div ? S_DIVIDE : S_COMMIT;
                end
            end
            S_DIVIDE:
            begin
                if (sts.div_last)
                begin
                    state_next = (sts.opcode == pfla_pkg::OP_ALLOC) ? S_ROUND : S_COMMIT;
                end
            end
            S_ROUND:
                state_next = S_COMMIT;
            S_COMMIT:
                state_next = S_DONE;
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign req_ready     = (state_reg == S_IDLE);
    assign cmd.accept    = (state_reg == S_IDLE) && req_valid;
    assign cmd.div_step  = (state_reg == S_DIVIDE);
    assign cmd.round_en  = (state_reg == S_ROUND);
    assign cmd.commit_en = (state_reg == S_COMMIT);
    assign cmd.load_out  = (state_reg == S_DONE) && sts.out_free;

endmodule

`default_nettype wire

>>> src/pfla_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pfla_dp #(
    parameter int MAX_FRAMES = pfla_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pfla_pkg::cmd_t      cmd,
    output pfla_pkg::sts_t           sts,
    input  wire pfla_pkg::cfg_t      cfg,
    input  wire pfla_pkg::req_word_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output pfla_pkg::rsp_word_t      rsp
);

    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(pfla_pkg::BC_W);
    localparam int AW      = pfla_pkg::ALIGN_W;
    localparam int RND_W   = pfla_pkg::BC_W + 1;
    localparam int SUM_W   = RND_W + 1;
    localparam int BASE_W  = FRAME_W + pfla_pkg::FSIZE_W;
    localparam int OFF_W   = ((BASE_W > pfla_pkg::FILL_W) ? BASE_W : pfla_pkg::FILL_W) + 1;
    localparam logic [AW-1:0]    MAX_C = AW'(MAX_FRAMES);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pfla_pkg::BC_W - 1);

    logic [pfla_pkg::OPCODE_W-1:0] op_reg;
    logic [pfla_pkg::BC_W-1:0]     bc_reg;
    logic [pfla_pkg::BC_W-1:0]     dvd_reg;
    logic [AW-1:0]                 divisor_reg;
    logic [AW-1:0]                 rem_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [RND_W-1:0]              rounded_reg;
    logic [BASE_W-1:0]             base_reg;
    logic [FRAME_W-1:0]            active_reg;
    logic [MAX_FRAMES-1:0]         valid_reg;
    logic                          granted_reg;
    logic [pfla_pkg::OFFSET_W-1:0] offset_reg;
    logic                          rsp_valid_reg;
    pfla_pkg::rsp_word_t           rsp_reg;

    logic [AW-1:0]                 align_eff;
    logic [AW-1:0]                 fc_ext;
    logic [AW-1:0]                 count_eff;
    logic [AW:0]                   trial;
    logic                          trial_ge;
    logic [AW-1:0]                 pad;
    logic [pfla_pkg::FILL_W-1:0]   fill_rd;
    logic [pfla_pkg::FILL_W-1:0]   fill;
    logic [SUM_W-1:0]              need_sum;
    logic                          fits;
    logic [OFF_W-1:0]              off_sum;
    logic                          ram_we;

    assign align_eff = (cfg.alignment == '0) ? AW'(1) : cfg.alignment;
    assign fc_ext    = AW'(cfg.frame_count);
    assign count_eff = (fc_ext == '0) ? AW'(1) : ((fc_ext > MAX_C) ? MAX_C : fc_ext);

    assign trial    = {rem_reg, dvd_reg[pfla_pkg::BC_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});

    assign pad = (rem_reg == '0) ? '0 : (divisor_reg - rem_reg);

    assign fill     = valid_reg[active_reg] ? fill_rd : '0;
    assign need_sum = SUM_W'(fill) + SUM_W'(rounded_reg);
    assign fits     = (need_sum <= SUM_W'(cfg.frame_size));
    assign off_sum  = OFF_W'(fill) + OFF_W'(base_reg);
    assign ram_we   = cmd.commit_en && (op_reg == pfla_pkg::OP_ALLOC) && fits;

    pfla_ram #(
        .WIDTH (pfla_pkg::FILL_W),
        .DEPTH (MAX_FRAMES)
    ) u_fill_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (active_reg),
        .wdata (need_sum[pfla_pkg::FILL_W-1:0]),
        .re    (cmd.accept),
        .raddr (active_reg),
        .rdata (fill_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= req.opcode;
            bc_reg  <= req.byte_count;
            rem_reg <= '0;
            if (req.opcode == pfla_pkg::OP_SWAP)
            begin
                dvd_reg     <= pfla_pkg::BC_W'(active_reg) + pfla_pkg::BC_W'(1);
                divisor_reg <= count_eff;
            end
            else
            begin
                dvd_reg     <= req.byte_count;
                divisor_reg <= align_eff;
            end
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[pfla_pkg::BC_W-2:0], 1'b0};
            rem_reg <= trial_ge ? AW'(trial - {1'b0, divisor_reg}) : trial[AW-1:0];
        end
        if (cmd.round_en)
        begin
            rounded_reg <= RND_W'(bc_reg) + RND_W'(pad);
            base_reg    <= BASE_W'(active_reg) * BASE_W'(cfg.frame_size);
        end
        if (cmd.commit_en)
        begin
            case (op_reg)
                pfla_pkg::OP_ALLOC:
                begin
                    granted_reg <= fits;
                    offset_reg  <= fits ? off_sum[pfla_pkg::OFFSET_W-1:0] : '0;
                end
                pfla_pkg::OP_FREE, pfla_pkg::OP_SWAP:
                begin
                    granted_reg <= 1'b1;
                    offset_reg  <= '0;
                end
                default:
                begin
                    granted_reg <= 1'b0;
                    offset_reg  <= '0;
                end
            endcase
        end
        if (cmd.load_out)
        begin
            rsp_reg.granted       <= granted_reg;
            rsp_reg.buffer_offset <= offset_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            active_reg    <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.commit_en)
            begin
                case (op_reg)
                    pfla_pkg::OP_ALLOC:
                    begin
                        if (fits)
                        begin
                            valid_reg[active_reg] <= 1'b1;
                        end
                    end
                    pfla_pkg::OP_FREE:
                        valid_reg[active_reg] <= 1'b0;
                    pfla_pkg::OP_SWAP:
                        active_reg <= rem_reg[FRAME_W-1:0];
                    default:
                        active_reg <= active_reg;
                endcase
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.req_div  = (req.opcode == pfla_pkg::OP_ALLOC) || (req.opcode == pfla_pkg::OP_SWAP);
    assign sts.opcode   = op_reg;
    assign sts.div_last = (cnt_reg == LAST_STEP);
    assign sts.out_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> src/per_frame_linear_allocator.sv
// Per-frame aligned bump allocator.
// Request channel (req_valid/req_ready/req): one word per operation, opcode
// allocate, free the active frame or swap to the next frame. Response channel
// (rsp_valid/rsp_ready/rsp): exactly one word per request, in request order,
// carrying granted and the buffer offset of a granted allocation.
// Configuration goes through the APB port: alignment at 0x0, frame_size at 0x4,
// frame_count at 0x8; pready is always high, writes land in the access cycle.
// Allocate and swap run a remainder unit one bit per cycle over 32 dividend
// bits; an allocate then rounds the size and commits, a swap commits, and free
// and unused opcodes go straight to commit. Each then loads the response into
// the output register once it is free. One request is in flight at a time.
// The response sits in an output register: the next request is accepted while
// an earlier response still waits for rsp_ready; a stalled receiver holds the
// block only once a second response is ready to load.
// Reset returns the registers to alignment 256, frame_size 65536,
// frame_count 1, makes frame 0 active and marks every frame fill as zero.
`timescale 1ns / 1ps
`default_nettype none

module per_frame_linear_allocator #(
    parameter int MAX_FRAMES = pfla_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire pfla_pkg::req_word_t         req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output pfla_pkg::rsp_word_t              rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pfla_pkg::APB_AW-1:0] paddr,
    input  wire logic [pfla_pkg::APB_DW-1:0] pwdata,
    output logic      [pfla_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    pfla_pkg::cfg_t cfg;
    pfla_pkg::cmd_t cmd;
    pfla_pkg::sts_t sts;

    pfla_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pfla_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg       (cfg),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
